FILE: rtl/page_replacement_policy_engine_assert.svh
// Assertion macros for the page replacement policy engine.
`ifndef PAGE_REPLACEMENT_POLICY_ENGINE_ASSERT_SVH
`define PAGE_REPLACEMENT_POLICY_ENGINE_ASSERT_SVH

`ifndef SYNTHESIS
`define PRPE_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");
`define PRPE_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define PRPE_ASSERT_SAME(label, ante, cons)
`define PRPE_ASSERT_NEXT(label, ante, cons)
`endif

`endif

FILE: rtl/prpe_pkg.sv
// Shared types, constants and codes of the page replacement policy engine.
`timescale 1ns / 1ps
package prpe_pkg;

  localparam int PRPE_FRAMES = 8;
  localparam int PAGE_W      = 8;
  localparam int COUNT_W     = 16;
  localparam int POS_W       = 3;
  localparam int MODE_W      = 3;
  localparam int FIU_W       = 4;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [COUNT_W-1:0] COUNT_ONE = COUNT_W'(1);

  localparam logic [MODE_W-1:0] MODE_FIFO     = 3'd0;
  localparam logic [MODE_W-1:0] MODE_LRU      = 3'd1;
  localparam logic [MODE_W-1:0] MODE_LFU_LRU  = 3'd2;
  localparam logic [MODE_W-1:0] MODE_MFU_FIFO = 3'd3;
  localparam logic [MODE_W-1:0] MODE_MFU_LRU  = 3'd4;

  localparam logic [0:0] REG_POLICY_MODE   = 1'b0;
  localparam logic [0:0] REG_FRAMES_IN_USE = 1'b1;

  localparam logic [MODE_W-1:0] MODE_RESET = MODE_FIFO;
  localparam logic [FIU_W-1:0]  FIU_RESET  = 4'd8;

  typedef struct packed {
    logic [PAGE_W-1:0]  page;
    logic [COUNT_W-1:0] count;
  } frame_t;

  typedef struct packed {
    logic [MODE_W-1:0] policy_mode;
    logic [FIU_W-1:0]  frames_in_use;
  } cfg_t;

  typedef struct packed {
    logic [PAGE_W-1:0] slot_page;
    logic [POS_W-1:0]  slot_position;
    logic              page_fault;
    logic              page_replaced;
    logic              last_slot;
  } out_item_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DECIDE,
    ST_SHIFT,
    ST_PLACE,
    ST_EMIT_RD,
    ST_EMIT_LD,
    ST_EMIT_WAIT
  } seq_state_t;

  function automatic logic [COUNT_W-1:0] bump_count(input logic [COUNT_W-1:0] c);
    bump_count = (c == COUNT_MAX) ? c : c + COUNT_ONE;
  endfunction

endpackage

FILE: rtl/prpe_ifs.sv
// Valid/ready channel interfaces for page references and list entries.
`timescale 1ns / 1ps
interface prpe_in_if import prpe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PAGE_W-1:0] page_ref;

  modport source (output valid, output page_ref, input ready);
  modport sink (input valid, input page_ref, output ready);
endinterface

interface prpe_out_if import prpe_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [PAGE_W-1:0] slot_page;
  logic [POS_W-1:0]  slot_position;
  logic              page_fault;
  logic              page_replaced;
  logic              last_slot;

  modport source (output valid, output slot_page, output slot_position,
                  output page_fault, output page_replaced, output last_slot,
                  input ready);
  modport sink (input valid, input slot_page, input slot_position,
                input page_fault, input page_replaced, input last_slot,
                output ready);
endinterface

FILE: rtl/prpe_cfg.sv
// APB register block holding the policy mode and the frame limit.
`timescale 1ns / 1ps
module prpe_cfg import prpe_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  output cfg_t        cfg
);

  logic [MODE_W-1:0] mode_r;
  logic [FIU_W-1:0]  fiu_r;
  logic [0:0]        reg_idx;
  logic              wr_en;

  assign reg_idx = paddr[2:2];
  assign wr_en   = psel & penable & pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r <= MODE_RESET;
      fiu_r  <= FIU_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        REG_POLICY_MODE:   mode_r <= pwdata[MODE_W-1:0];
        REG_FRAMES_IN_USE: fiu_r  <= pwdata[FIU_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      REG_POLICY_MODE:   prdata = {{(32-MODE_W){1'b0}}, mode_r};
      REG_FRAMES_IN_USE: prdata = {{(32-FIU_W){1'b0}}, fiu_r};
      default:           prdata = '0;
    endcase
  end

  assign cfg.policy_mode   = mode_r;
  assign cfg.frames_in_use = fiu_r;

endmodule

FILE: rtl/prpe_frame_mem.sv
// Frame list memory: page id and use count per position, registered read.
`timescale 1ns / 1ps
module prpe_frame_mem import prpe_pkg::*; #(
  parameter int FRAMES = PRPE_FRAMES,
  parameter int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1
) (
  input  logic             clk,
  input  logic [IDX_W-1:0] rd_addr,
  output frame_t           rd_data,
  input  logic             wr_en,
  input  logic [IDX_W-1:0] wr_addr,
  input  frame_t           wr_data
);

  frame_t mem [FRAMES];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

FILE: rtl/prpe_seq.sv
// Sequencer: scan, victim pick, list shift, placement and list readout.
`timescale 1ns / 1ps
module prpe_seq import prpe_pkg::*; #(
  parameter int FRAMES = PRPE_FRAMES,
  parameter int IDX_W  = (FRAMES > 1) ? $clog2(FRAMES) : 1,
  parameter int OCC_W  = $clog2(FRAMES + 1)
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cfg_t              cfg,
  prpe_in_if.sink           in_chan,
  prpe_out_if.source        out_chan,
  output logic [IDX_W-1:0]  mem_rd_addr,
  input  frame_t            mem_rd_data,
  output logic              mem_wr_en,
  output logic [IDX_W-1:0]  mem_wr_addr,
  output frame_t            mem_wr_data
);

  localparam int CMP_W = (OCC_W > FIU_W) ? OCC_W : FIU_W;

  seq_state_t         state_r, state_nxt;
  logic [PAGE_W-1:0]  page_r, page_nxt;
  logic [OCC_W-1:0]   occ_r, occ_nxt;
  logic [OCC_W-1:0]   k_r, k_nxt;
  logic               pend_r, pend_nxt;
  logic [IDX_W-1:0]   pend_pos_r, pend_pos_nxt;
  logic               hit_r, hit_nxt;
  logic [IDX_W-1:0]   hit_pos_r, hit_pos_nxt;
  logic [COUNT_W-1:0] hit_cnt_r, hit_cnt_nxt;
  logic [IDX_W-1:0]   vic_pos_r, vic_pos_nxt;
  logic [COUNT_W-1:0] vic_cnt_r, vic_cnt_nxt;
  frame_t             place_r, place_nxt;
  logic [IDX_W-1:0]   place_pos_r, place_pos_nxt;
  logic               fault_r, fault_nxt;
  logic               repl_r, repl_nxt;
  out_item_t          out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  logic [MODE_W-1:0]  mode;
  logic [CMP_W-1:0]   fiu_c;
  logic [CMP_W-1:0]   lim_c;
  logic               full;
  logic [OCC_W-1:0]   k_dec;
  logic [OCC_W-1:0]   k_inc;
  logic [OCC_W-1:0]   occ_dec;
  logic               better;
  logic               count_mode;

  assign mode  = (cfg.policy_mode > MODE_MFU_LRU) ? MODE_FIFO : cfg.policy_mode;
  assign fiu_c = CMP_W'(cfg.frames_in_use);

  always_comb begin
    lim_c = (fiu_c == '0) ? CMP_W'(1) : fiu_c;
    if (lim_c > CMP_W'(FRAMES)) begin
      lim_c = CMP_W'(FRAMES);
    end
  end

  assign full       = CMP_W'(occ_r) >= lim_c;
  assign k_dec      = k_r - 1'b1;
  assign k_inc      = k_r + 1'b1;
  assign occ_dec    = occ_r - 1'b1;
  assign count_mode = (mode == MODE_LFU_LRU) || (mode == MODE_MFU_FIFO) ||
                      (mode == MODE_MFU_LRU);
  assign better     = (mode == MODE_LFU_LRU) ? (mem_rd_data.count <= vic_cnt_r)
                                             : (mem_rd_data.count >= vic_cnt_r);

  assign in_chan.ready          = (state_r == ST_IDLE);
  assign out_chan.valid         = out_valid_r;
  assign out_chan.slot_page     = out_r.slot_page;
  assign out_chan.slot_position = out_r.slot_position;
  assign out_chan.page_fault    = out_r.page_fault;
  assign out_chan.page_replaced = out_r.page_replaced;
  assign out_chan.last_slot     = out_r.last_slot;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      occ_r       <= '0;
      k_r         <= '0;
      pend_r      <= 1'b0;
      hit_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      occ_r       <= occ_nxt;
      k_r         <= k_nxt;
      pend_r      <= pend_nxt;
      hit_r       <= hit_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    page_r      <= page_nxt;
    pend_pos_r  <= pend_pos_nxt;
    hit_pos_r   <= hit_pos_nxt;
    hit_cnt_r   <= hit_cnt_nxt;
    vic_pos_r   <= vic_pos_nxt;
    vic_cnt_r   <= vic_cnt_nxt;
    place_r     <= place_nxt;
    place_pos_r <= place_pos_nxt;
    fault_r     <= fault_nxt;
    repl_r      <= repl_nxt;
    out_r       <= out_nxt;
  end

  always_comb begin
    state_nxt     = state_r;
    page_nxt      = page_r;
    occ_nxt       = occ_r;
    k_nxt         = k_r;
    pend_nxt      = pend_r;
    pend_pos_nxt  = pend_pos_r;
    hit_nxt       = hit_r;
    hit_pos_nxt   = hit_pos_r;
    hit_cnt_nxt   = hit_cnt_r;
    vic_pos_nxt   = vic_pos_r;
    vic_cnt_nxt   = vic_cnt_r;
    place_nxt     = place_r;
    place_pos_nxt = place_pos_r;
    fault_nxt     = fault_r;
    repl_nxt      = repl_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    mem_rd_addr   = k_r[IDX_W-1:0];
    mem_wr_en     = 1'b0;
    mem_wr_addr   = place_pos_r;
    mem_wr_data   = place_r;

    case (state_r)
      ST_IDLE: begin
        if (in_chan.valid) begin
          page_nxt  = in_chan.page_ref;
          k_nxt     = '0;
          pend_nxt  = 1'b0;
          hit_nxt   = 1'b0;
          state_nxt = ST_SCAN;
        end
      end

      ST_SCAN: begin
        if (pend_r) begin
          if (!hit_r && (mem_rd_data.page == page_r)) begin
            hit_nxt     = 1'b1;
            hit_pos_nxt = pend_pos_r;
            hit_cnt_nxt = mem_rd_data.count;
          end
          if ((pend_pos_r == '0) || better) begin
            vic_pos_nxt = pend_pos_r;
            vic_cnt_nxt = mem_rd_data.count;
          end
        end
        if (k_r != occ_r) begin
          pend_nxt     = 1'b1;
          pend_pos_nxt = k_r[IDX_W-1:0];
          k_nxt        = k_inc;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = ST_DECIDE;
          end
        end
      end

      ST_DECIDE: begin
        state_nxt = ST_SHIFT;
        pend_nxt  = 1'b0;
        if (!hit_r) begin
          fault_nxt     = 1'b1;
          place_nxt     = '{page: page_r, count: COUNT_ONE};
          place_pos_nxt = '0;
          if (full) begin
            repl_nxt = 1'b1;
            k_nxt    = count_mode ? OCC_W'(vic_pos_r) : occ_dec;
          end else begin
            repl_nxt = 1'b0;
            k_nxt    = occ_r;
            occ_nxt  = occ_r + 1'b1;
          end
        end else begin
          fault_nxt = 1'b0;
          repl_nxt  = 1'b0;
          case (mode)
            MODE_LRU: begin
              place_nxt     = '{page: page_r, count: hit_cnt_r};
              place_pos_nxt = '0;
              k_nxt         = OCC_W'(hit_pos_r);
            end
            MODE_LFU_LRU, MODE_MFU_LRU: begin
              place_nxt     = '{page: page_r, count: bump_count(hit_cnt_r)};
              place_pos_nxt = '0;
              k_nxt         = OCC_W'(hit_pos_r);
            end
            MODE_MFU_FIFO: begin
              place_nxt     = '{page: page_r, count: bump_count(hit_cnt_r)};
              place_pos_nxt = hit_pos_r;
              k_nxt         = '0;
            end
            default: begin
              place_nxt     = '{page: page_r, count: hit_cnt_r};
              place_pos_nxt = hit_pos_r;
              k_nxt         = '0;
            end
          endcase
        end
      end

      ST_SHIFT: begin
        mem_rd_addr = k_dec[IDX_W-1:0];
        if (pend_r) begin
          mem_wr_en   = 1'b1;
          mem_wr_addr = pend_pos_r + 1'b1;
          mem_wr_data = mem_rd_data;
        end
        if (k_r != '0) begin
          pend_nxt     = 1'b1;
          pend_pos_nxt = k_dec[IDX_W-1:0];
          k_nxt        = k_dec;
        end else begin
          pend_nxt = 1'b0;
          if (!pend_r) begin
            state_nxt = ST_PLACE;
          end
        end
      end

      ST_PLACE: begin
        mem_wr_en   = 1'b1;
        mem_wr_addr = place_pos_r;
        mem_wr_data = place_r;
        k_nxt       = '0;
        state_nxt   = ST_EMIT_RD;
      end

      ST_EMIT_RD: begin
        state_nxt = ST_EMIT_LD;
      end

      ST_EMIT_LD: begin
        out_nxt.slot_page     = mem_rd_data.page;
        out_nxt.slot_position = POS_W'(k_r);
        out_nxt.page_fault    = fault_r;
        out_nxt.page_replaced = repl_r;
        out_nxt.last_slot     = (k_inc == occ_r);
        out_valid_nxt         = 1'b1;
        state_nxt             = ST_EMIT_WAIT;
      end

      ST_EMIT_WAIT: begin
        if (out_chan.ready) begin
          out_valid_nxt = 1'b0;
          k_nxt         = k_inc;
          state_nxt     = out_r.last_slot ? ST_IDLE : ST_EMIT_RD;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/page_replacement_policy_engine.sv
// Page replacement policy engine, top level.
// A page reference enters on in_chan (valid/ready, field page_ref). The
// block looks it up in its frame list, applies the policy selected by the
// policy_mode register (FIFO, LRU, LFU-LRU, MFU-FIFO, MFU-LRU), then sends
// the whole resident list on out_chan, front first, one transfer per entry,
// with last_slot set on the final entry and the fault/replace flags on all.
// Registers policy_mode (0x0) and frames_in_use (0x4) sit on the APB port;
// write them only while no reference is in flight.
// in_chan.ready is high only between items. An accepted reference goes
// through scan and decision, then list shift and placement, then a read of
// each entry from the front; the results follow one by one, and the next
// reference is accepted only after the final entry has been taken.
// The single memory port pair of the frame list and the one compare unit
// make these steps run in turn.
// A stalled receiver holds the current entry in the output register and the
// sequencer waits; nothing is dropped.
// Reset (rst_n low at a clock edge) empties the list and restores FIFO mode
// with eight frames; frame contents stay as they were and are never read.
`timescale 1ns / 1ps
`include "page_replacement_policy_engine_assert.svh"
module page_replacement_policy_engine import prpe_pkg::*; #(
  parameter int FRAMES = PRPE_FRAMES
) (
  input  logic        clk,
  input  logic        rst_n,
  prpe_in_if.sink     in_chan,
  prpe_out_if.source  out_chan,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int IDX_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int OCC_W = $clog2(FRAMES + 1);

  cfg_t             cfg;
  logic [IDX_W-1:0] mem_rd_addr;
  frame_t           mem_rd_data;
  logic             mem_wr_en;
  logic [IDX_W-1:0] mem_wr_addr;
  frame_t           mem_wr_data;
  logic             out_last_xfer;

  prpe_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  prpe_frame_mem #(
    .FRAMES (FRAMES),
    .IDX_W  (IDX_W)
  ) u_mem (
    .clk     (clk),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (mem_wr_data)
  );

  prpe_seq #(
    .FRAMES (FRAMES),
    .IDX_W  (IDX_W),
    .OCC_W  (OCC_W)
  ) u_seq (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg         (cfg),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .mem_rd_addr (mem_rd_addr),
    .mem_rd_data (mem_rd_data),
    .mem_wr_en   (mem_wr_en),
    .mem_wr_addr (mem_wr_addr),
    .mem_wr_data (mem_wr_data)
  );

  assign out_last_xfer = out_chan.valid && out_chan.ready && out_chan.last_slot;

  `PRPE_ASSERT_SAME(a_ready_not_emitting, in_chan.ready, !out_chan.valid)
  `PRPE_ASSERT_NEXT(a_busy_after_accept, in_chan.valid && in_chan.ready, !in_chan.ready)
  `PRPE_ASSERT_NEXT(a_idle_after_last, out_last_xfer, in_chan.ready)

endmodule

FILE: tb/testbench.sv
// Self-checking testbench of the page replacement policy engine.
`timescale 1ns / 1ps
module testbench;
  import prpe_pkg::*;

  localparam int HOLD_CYCLES    = 300;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 60;
  localparam int BUMP_HITS      = 3;
  localparam int RAND_PHASES    = 8;
  localparam int PHASE_ITEMS    = 24;

  typedef enum {ROW_REF, ROW_CFG, ROW_HOLD} row_kind_t;

  typedef struct {
    row_kind_t                  kind;
    logic [0:0]                 reg_sel;
    logic [31:0]                value;
    logic [PAGE_W-1:0]          page;
    bit                         typed;
    bit                         fault;
    bit                         repl;
    int                         n;
    logic [2:0][PAGE_W-1:0]     pages;
  } script_row_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  prpe_in_if  in_chan ();
  prpe_out_if out_chan ();

  page_replacement_policy_engine dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan),
    .psel     (psel),
    .penable  (penable),
    .pwrite   (pwrite),
    .paddr    (paddr),
    .pwdata   (pwdata),
    .prdata   (prdata),
    .pready   (pready)
  );

  logic [PAGE_W-1:0]  frame_page_mdl  [0:PRPE_FRAMES-1];
  logic [COUNT_W-1:0] frame_count_mdl [0:PRPE_FRAMES-1];
  int                 resident;
  logic [MODE_W-1:0]  pol_mode;
  logic [FIU_W-1:0]   frame_limit;

  out_item_t   predicted_slots [$];
  out_item_t   expected_slots  [$];
  script_row_t ref_script      [$];

  int burst_left;
  int err_count;
  bit long_hold_req;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic void apply_reference(input logic [PAGE_W-1:0] page);
    logic [MODE_W-1:0]  mode;
    int                 lim;
    int                 hit_idx;
    int                 victim;
    int                 k;
    logic               fault;
    logic               repl;
    logic [PAGE_W-1:0]  move_page;
    logic [COUNT_W-1:0] move_count;
    out_item_t          slot;
    mode = (pol_mode > MODE_MFU_LRU) ? MODE_FIFO : pol_mode;
    lim = (frame_limit == 0) ? 1 : (frame_limit > PRPE_FRAMES) ? PRPE_FRAMES : int'(frame_limit);
    fault = 1'b0;
    repl = 1'b0;
    hit_idx = resident;
    for (k = resident - 1; k >= 0; k--) begin
      if (frame_page_mdl[k] == page) hit_idx = k;
    end
    if (hit_idx >= resident) begin
      fault = 1'b1;
      if (resident >= lim) begin
        victim = resident - 1;
        if (mode == MODE_LFU_LRU || mode == MODE_MFU_FIFO || mode == MODE_MFU_LRU) begin
          for (k = resident - 2; k >= 0; k--) begin
            if (mode == MODE_LFU_LRU) begin
              if (frame_count_mdl[k] < frame_count_mdl[victim]) victim = k;
            end else begin
              if (frame_count_mdl[k] > frame_count_mdl[victim]) victim = k;
            end
          end
        end
        for (k = victim; k < resident - 1; k++) begin
          frame_page_mdl[k]  = frame_page_mdl[k+1];
          frame_count_mdl[k] = frame_count_mdl[k+1];
        end
        resident--;
        repl = 1'b1;
      end
      for (k = resident; k > 0; k--) begin
        frame_page_mdl[k]  = frame_page_mdl[k-1];
        frame_count_mdl[k] = frame_count_mdl[k-1];
      end
      frame_page_mdl[0]  = page;
      frame_count_mdl[0] = COUNT_ONE;
      resident++;
    end else if (mode == MODE_MFU_FIFO) begin
      if (frame_count_mdl[hit_idx] != COUNT_MAX) frame_count_mdl[hit_idx]++;
    end else if (mode != MODE_FIFO) begin
      move_page  = frame_page_mdl[hit_idx];
      move_count = frame_count_mdl[hit_idx];
      for (k = hit_idx; k > 0; k--) begin
        frame_page_mdl[k]  = frame_page_mdl[k-1];
        frame_count_mdl[k] = frame_count_mdl[k-1];
      end
      frame_page_mdl[0]  = move_page;
      frame_count_mdl[0] = move_count;
      if (mode != MODE_LRU && move_count != COUNT_MAX) frame_count_mdl[0]++;
    end
    predicted_slots.delete();
    for (k = 0; k < resident; k++) begin
      slot.slot_page     = frame_page_mdl[k];
      slot.slot_position = POS_W'(k);
      slot.page_fault    = fault;
      slot.page_replaced = repl;
      slot.last_slot     = (k == resident - 1);
      predicted_slots.insert(predicted_slots.size(), slot);
    end
  endfunction

  function automatic void add_cfg(input logic [0:0] reg_sel, input logic [31:0] value);
    script_row_t row;
    row = '{kind: ROW_CFG, default: 0};
    row.kind    = ROW_CFG;
    row.reg_sel = reg_sel;
    row.value   = value;
    ref_script.insert(ref_script.size(), row);
  endfunction

  function automatic void add_ref(input logic [PAGE_W-1:0] page, input int count);
    script_row_t row;
    row = '{kind: ROW_REF, default: 0};
    row.kind  = ROW_REF;
    row.page  = page;
    row.value = count;
    ref_script.insert(ref_script.size(), row);
  endfunction

  function automatic void add_check(input logic [PAGE_W-1:0] page, input bit fault,
                                    input bit repl, input int n,
                                    input logic [PAGE_W-1:0] p0,
                                    input logic [PAGE_W-1:0] p1,
                                    input logic [PAGE_W-1:0] p2);
    script_row_t row;
    row = '{kind: ROW_REF, default: 0};
    row.kind     = ROW_REF;
    row.page     = page;
    row.value    = 1;
    row.typed    = 1'b1;
    row.fault    = fault;
    row.repl     = repl;
    row.n        = n;
    row.pages[0] = p0;
    row.pages[1] = p1;
    row.pages[2] = p2;
    ref_script.insert(ref_script.size(), row);
  endfunction

  task automatic write_register(input logic [0:0] reg_sel, input logic [31:0] value);
    logic [31:0] readback;
    logic [31:0] want;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {reg_sel, 2'b00};
    pwdata  <= value;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (reg_sel == REG_POLICY_MODE) begin
      pol_mode = value[MODE_W-1:0];
      want = 32'(value[MODE_W-1:0]);
    end else begin
      frame_limit = value[FIU_W-1:0];
      want = 32'(value[FIU_W-1:0]);
    end
    @(negedge clk);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(negedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    readback = prdata;
    @(negedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    if (readback !== want) begin
      $error("prdata mismatch: expected %0h, actual %0h", want, readback);
      err_count++;
    end
    @(negedge clk);
  endtask

  task automatic offer_page(input script_row_t row);
    int        gap;
    int        k;
    out_item_t slot;
    if (burst_left == 0) begin
      burst_left = $urandom_range(4, 20);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 4);
      if (gap != 0) begin
        in_chan.valid <= 1'b0;
        repeat (gap) @(negedge clk);
      end
    end
    burst_left--;
    in_chan.valid    <= 1'b1;
    in_chan.page_ref <= row.page;
    do @(posedge clk); while (!in_chan.ready);
    apply_reference(row.page);
    if (row.typed) begin
      for (k = 0; k < row.n; k++) begin
        slot.slot_page     = row.pages[k];
        slot.slot_position = POS_W'(k);
        slot.page_fault    = row.fault;
        slot.page_replaced = row.repl;
        slot.last_slot     = (k == row.n - 1);
        expected_slots.insert(expected_slots.size(), slot);
      end
    end else begin
      for (k = 0; k < predicted_slots.size(); k++) begin
        expected_slots.insert(expected_slots.size(), predicted_slots[k]);
      end
    end
    @(negedge clk);
  endtask

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_chan.valid && out_chan.ready) begin
      if (expected_slots.size() == 0) begin
        $error("unexpected transfer: slot_page %0d slot_position %0d",
               out_chan.slot_page, out_chan.slot_position);
        err_count++;
      end else begin
        want = expected_slots.pop_front();
        if (out_chan.slot_page !== want.slot_page) begin
          $error("slot_page mismatch: expected %0d, actual %0d",
                 want.slot_page, out_chan.slot_page);
          err_count++;
        end
        if (out_chan.slot_position !== want.slot_position) begin
          $error("slot_position mismatch: expected %0d, actual %0d",
                 want.slot_position, out_chan.slot_position);
          err_count++;
        end
        if (out_chan.page_fault !== want.page_fault) begin
          $error("page_fault mismatch: expected %0d, actual %0d",
                 want.page_fault, out_chan.page_fault);
          err_count++;
        end
        if (out_chan.page_replaced !== want.page_replaced) begin
          $error("page_replaced mismatch: expected %0d, actual %0d",
                 want.page_replaced, out_chan.page_replaced);
          err_count++;
        end
        if (out_chan.last_slot !== want.last_slot) begin
          $error("last_slot mismatch: expected %0d, actual %0d",
                 want.last_slot, out_chan.last_slot);
          err_count++;
        end
      end
    end
  end

  initial begin : receiver
    int pattern;
    int left;
    pattern = 0;
    left = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold_req) begin
        long_hold_req = 1'b0;
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(negedge clk);
      end
      if (left == 0) begin
        pattern = $urandom_range(0, 9);
        left = $urandom_range(16, 80);
      end
      left--;
      case (pattern)
        0, 1, 2, 3: out_chan.ready <= 1'b1;
        4, 5, 6:    out_chan.ready <= $urandom_range(0, 1);
        7:          out_chan.ready <= (left % 4 == 0);
        default:    out_chan.ready <= ($urandom_range(0, 4) != 0);
      endcase
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("page_replacement_policy_engine regression: fail");
    $finish;
  end

  initial begin : main_seq
    script_row_t       row;
    int                p;
    int                i;
    int                n;
    int                lim;
    int                pool_size;
    logic [FIU_W-1:0]  fiu;
    logic [PAGE_W-1:0] pool [0:11];

    rst_n            = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    in_chan.valid    = 1'b0;
    in_chan.page_ref = '0;
    pol_mode         = MODE_RESET;
    frame_limit      = FIU_RESET;
    resident         = 0;
    burst_left       = 0;
    err_count        = 0;
    long_hold_req    = 1'b0;

    // directed: reset defaults, use counts, frame limit edges, every mode
    add_check(8'd0, 1, 0, 1, 8'd0, 8'd0, 8'd0);
    add_cfg(REG_POLICY_MODE, 32'(MODE_MFU_FIFO));
    add_ref(8'd0, BUMP_HITS);
    add_check(8'd255, 1, 0, 2, 8'd255, 8'd0, 8'd0);
    add_cfg(REG_FRAMES_IN_USE, 32'd2);
    add_check(8'd7, 1, 1, 2, 8'd7, 8'd255, 8'd0);
    add_cfg(REG_POLICY_MODE, 32'(MODE_FIFO));
    add_cfg(REG_FRAMES_IN_USE, 32'd0);
    add_check(8'd9, 1, 1, 2, 8'd9, 8'd7, 8'd0);
    add_check(8'd7, 0, 0, 2, 8'd9, 8'd7, 8'd0);
    add_cfg(REG_FRAMES_IN_USE, 32'd15);
    add_check(8'd3, 1, 0, 3, 8'd3, 8'd9, 8'd7);
    add_cfg(REG_POLICY_MODE, 32'(MODE_LRU));
    add_check(8'd7, 0, 0, 3, 8'd7, 8'd3, 8'd9);
    add_cfg(REG_POLICY_MODE, 32'd7);
    add_check(8'd9, 0, 0, 3, 8'd7, 8'd3, 8'd9);
    add_cfg(REG_POLICY_MODE, 32'(MODE_LFU_LRU));
    add_cfg(REG_FRAMES_IN_USE, 32'd4);
    add_check(8'd3, 0, 0, 3, 8'd3, 8'd7, 8'd9);
    add_ref(8'd128, 1);
    add_ref(8'd64, 1);
    add_cfg(REG_POLICY_MODE, 32'(MODE_MFU_LRU));
    add_ref(8'd7, 1);
    add_ref(8'd1, 1);
    add_cfg(REG_POLICY_MODE, 32'(MODE_MFU_FIFO));
    add_ref(8'd64, 1);
    add_ref(8'd254, 1);
    add_cfg(REG_POLICY_MODE, 32'(MODE_LRU));
    add_cfg(REG_FRAMES_IN_USE, 32'd8);
    add_ref(8'd170, 1);
    add_ref(8'd85, 1);

    // random: one phase per mode code, small working sets so hits dominate
    for (p = 0; p < RAND_PHASES; p++) begin
      add_cfg(REG_POLICY_MODE, (32'($urandom) & 32'hFFFF_FFF8) | 32'(p));
      if ($urandom_range(0, 3) == 0) fiu = FIU_W'($urandom_range(0, 15));
      else fiu = FIU_W'($urandom_range(1, PRPE_FRAMES));
      add_cfg(REG_FRAMES_IN_USE, (32'($urandom) & 32'hFFFF_FFF0) | 32'(fiu));
      lim = (fiu == 0) ? 1 : (fiu > PRPE_FRAMES) ? PRPE_FRAMES : int'(fiu);
      pool_size = lim + $urandom_range(1, 4);
      for (i = 0; i < pool_size; i++) pool[i] = PAGE_W'($urandom_range(0, 255));
      if (p == 3) begin
        row = '{kind: ROW_HOLD, default: 0};
        ref_script.insert(ref_script.size(), row);
      end
      for (i = 0; i < PHASE_ITEMS; i++) begin
        if ($urandom_range(0, 99) < 85) add_ref(pool[$urandom_range(0, pool_size - 1)], 1);
        else add_ref(PAGE_W'($urandom_range(0, 255)), 1);
      end
    end

    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    for (i = 0; i < ref_script.size(); i++) begin
      row = ref_script[i];
      case (row.kind)
        ROW_CFG: begin
          in_chan.valid <= 1'b0;
          while (expected_slots.size() != 0) @(negedge clk);
          write_register(row.reg_sel, row.value);
        end
        ROW_HOLD: long_hold_req = 1'b1;
        default: begin
          for (n = 0; n < int'(row.value); n++) offer_page(row);
        end
      endcase
    end

    in_chan.valid <= 1'b0;
    while (expected_slots.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (err_count == 0 && expected_slots.size() == 0)
      $display("page_replacement_policy_engine regression: pass");
    else
      $display("page_replacement_policy_engine regression: fail");
    $finish;
  end

endmodule

FILE: sim.f
+incdir+rtl
rtl/prpe_pkg.sv
rtl/prpe_ifs.sv
rtl/prpe_cfg.sv
rtl/prpe_frame_mem.sv
rtl/prpe_seq.sv
rtl/page_replacement_policy_engine.sv
tb/testbench.sv
